@@ sv/assert_macros.svh @@
// Assertion helpers included by particle_cell_binning_core.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PCB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define PCB_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

@@ sv/pcb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcb_pkg
// Shared widths, codes and types of the particle cell binning core.
// ----------------------------------------------------------------------------
package pcb_pkg;

  localparam int unsigned AXIS_BITS = 10;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned INV_W   = 24;
  localparam int unsigned HALO_W  = 8;
  localparam int unsigned IDX_W   = 30;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam logic [INV_W-1:0]  INV_LEN_RESET    = INV_W'(65536);
  localparam int unsigned       GRID_RESET_COUNT = 16;
  localparam logic [HALO_W-1:0] HALO_RESET       = HALO_W'(1);

  typedef enum logic [CLASS_W-1:0] {
    CLASS_INNER    = 2'd0,
    CLASS_BOUNDARY = 2'd1,
    CLASS_HALO     = 2'd2
  } cell_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_INV_LEN_X = 3'd3,
    REG_INV_LEN_Y = 3'd4,
    REG_INV_LEN_Z = 3'd5,
    REG_GRID_DIMS = 3'd6,
    REG_HALO      = 3'd7
  } cfg_reg_e;

  // Load enables of the three per-axis stages
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
  } axis_adv_t;

endpackage

@@ sv/pcb_axis.sv @@
// ----------------------------------------------------------------------------
// pcb_axis
// One axis of the binning pipeline: offset, reciprocal multiply, range check
// and halo/boundary classification over three register stages.
// ----------------------------------------------------------------------------
module pcb_axis #(
  parameter int unsigned AxisBits = pcb_pkg::AXIS_BITS
) (
  input  logic                          clk_i,
  input  pcb_pkg::axis_adv_t            adv_i,
  input  logic signed [pcb_pkg::POS_W-1:0] pos_i,
  input  logic [pcb_pkg::POS_W-1:0]     origin_i,
  input  logic [pcb_pkg::INV_W-1:0]     inv_len_i,
  input  logic [AxisBits-1:0]           count_i,
  input  logic [pcb_pkg::HALO_W-1:0]    halo_i,
  output logic [AxisBits-1:0]           coord_o,
  output logic                          in_range_o,
  output pcb_pkg::cell_class_e          class_o
);

  localparam int unsigned DiffW = pcb_pkg::POS_W + 1;
  localparam int unsigned ProdW = pcb_pkg::POS_W + pcb_pkg::INV_W;
  localparam int unsigned ClsW  = AxisBits + pcb_pkg::HALO_W + 2;

  // stage 0: exact signed offset
  logic [DiffW-1:0] diff_d, diff_q;

  assign diff_d = {pos_i[pcb_pkg::POS_W-1], pos_i} - {origin_i[pcb_pkg::POS_W-1], origin_i};

  always_ff @(posedge clk_i) begin
    if (adv_i.s0) begin
      diff_q <= diff_d;
    end
  end

  // stage 1: scale by reciprocal, keep the integer part
  logic [ProdW-1:0]          prod;
  logic [pcb_pkg::INV_W-1:0] cell_d, cell_q;
  logic                      neg_q;

  assign prod   = ProdW'(diff_q[pcb_pkg::POS_W-1:0]) * ProdW'(inv_len_i);
  assign cell_d = prod[ProdW-1:pcb_pkg::POS_W];

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      cell_q <= cell_d;
      neg_q  <= diff_q[DiffW-1];
    end
  end

  // stage 2: range check and classification
  logic [ClsW-1:0]      c_w, h_w, h2_w, n_w;
  logic                 is_halo, is_bnd, in_range_d;
  pcb_pkg::cell_class_e class_d;

  assign c_w  = ClsW'(cell_q[AxisBits-1:0]);
  assign h_w  = ClsW'(halo_i);
  assign h2_w = ClsW'({halo_i, 1'b0});
  // zero halo width: lift the upper limit out of reach
  assign n_w  = ClsW'(count_i) + ClsW'(halo_i == '0);

  assign is_halo    = (c_w < h_w) || (c_w + h_w >= n_w);
  assign is_bnd     = (c_w < h2_w) || (c_w + h2_w >= n_w);
  assign in_range_d = !neg_q && (cell_q < pcb_pkg::INV_W'(count_i));

  always_comb begin
    if (is_halo) begin
      class_d = pcb_pkg::CLASS_HALO;
    end else if (is_bnd) begin
      class_d = pcb_pkg::CLASS_BOUNDARY;
    end else begin
      class_d = pcb_pkg::CLASS_INNER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      coord_o    <= cell_q[AxisBits-1:0];
      in_range_o <= in_range_d;
      class_o    <= class_d;
    end
  end

endmodule

@@ sv/particle_cell_binning_core.sv @@
// ----------------------------------------------------------------------------
// particle_cell_binning_core
// Bins one particle position into a 3D linked-cell grid per word.
// ----------------------------------------------------------------------------
// Five-stage pipeline: offset, reciprocal multiply, range check and
// classification, then the two multiply-adds of the linear index, the last
// one landing in the output register. Each stage registers the word in turn,
// from stage 0 up to the output register; the core takes one word per cycle
// and holds its whole contents while out_stall_i is high, only
// raising in_stall_o once every stage is occupied. The per-stage multipliers
// (32x24 per axis, then two 30-bit index products) set the stage depth.
// Write configuration only while no word is in flight.
module particle_cell_binning_core #(
  parameter int unsigned AxisBits = pcb_pkg::AXIS_BITS,
  localparam int unsigned CfgW = (3 * AxisBits > pcb_pkg::POS_W) ? 3 * AxisBits
                                                                 : pcb_pkg::POS_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CfgW-1:0]                   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pcb_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [pcb_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [pcb_pkg::POS_W-1:0]  pos_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pcb_pkg::IDX_W-1:0]         cell_index_o,
  output logic [pcb_pkg::CLASS_W-1:0]       cell_class_o,
  output logic                              out_of_range_o
);

  `include "assert_macros.svh"

  localparam int unsigned NumStages = 5;
  localparam int unsigned IdxW      = pcb_pkg::IDX_W;
  localparam int unsigned DimsW     = 3 * AxisBits;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [pcb_pkg::POS_W-1:0]  origin_x_q, origin_y_q, origin_z_q;
  logic [pcb_pkg::INV_W-1:0]  inv_x_q, inv_y_q, inv_z_q;
  logic [DimsW-1:0]           dims_q;
  logic [pcb_pkg::HALO_W-1:0] halo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      inv_x_q    <= pcb_pkg::INV_LEN_RESET;
      inv_y_q    <= pcb_pkg::INV_LEN_RESET;
      inv_z_q    <= pcb_pkg::INV_LEN_RESET;
      dims_q     <= {3{AxisBits'(pcb_pkg::GRID_RESET_COUNT)}};
      halo_q     <= pcb_pkg::HALO_RESET;
    end else if (cfg_we_i) begin
      case (pcb_pkg::cfg_reg_e'(cfg_idx_i))
        pcb_pkg::REG_ORIGIN_X:  origin_x_q <= cfg_wdata_i[pcb_pkg::POS_W-1:0];
        pcb_pkg::REG_ORIGIN_Y:  origin_y_q <= cfg_wdata_i[pcb_pkg::POS_W-1:0];
        pcb_pkg::REG_ORIGIN_Z:  origin_z_q <= cfg_wdata_i[pcb_pkg::POS_W-1:0];
        pcb_pkg::REG_INV_LEN_X: inv_x_q    <= cfg_wdata_i[pcb_pkg::INV_W-1:0];
        pcb_pkg::REG_INV_LEN_Y: inv_y_q    <= cfg_wdata_i[pcb_pkg::INV_W-1:0];
        pcb_pkg::REG_INV_LEN_Z: inv_z_q    <= cfg_wdata_i[pcb_pkg::INV_W-1:0];
        pcb_pkg::REG_GRID_DIMS: dims_q     <= cfg_wdata_i[DimsW-1:0];
        pcb_pkg::REG_HALO:      halo_q     <= cfg_wdata_i[pcb_pkg::HALO_W-1:0];
        default: ;
      endcase
    end
  end

  logic [AxisBits-1:0] nx, ny, nz;

  assign nx = dims_q[AxisBits-1:0];
  assign ny = dims_q[2*AxisBits-1:AxisBits];
  assign nz = dims_q[3*AxisBits-1:2*AxisBits];

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or the next one loads
  // --------------------------------------------------------------------------
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NumStages-1];

  // --------------------------------------------------------------------------
  // Stages 0..2: per-axis binning
  // --------------------------------------------------------------------------
  pcb_pkg::axis_adv_t   axis_adv;
  logic [AxisBits-1:0]  cx, cy, cz;
  logic                 okx, oky, okz;
  pcb_pkg::cell_class_e clsx, clsy, clsz;

  assign axis_adv = '{s0: adv[0], s1: adv[1], s2: adv[2]};

  pcb_axis #(.AxisBits(AxisBits)) u_axis_x (
    .clk_i      (clk_i),
    .adv_i      (axis_adv),
    .pos_i      (pos_x_i),
    .origin_i   (origin_x_q),
    .inv_len_i  (inv_x_q),
    .count_i    (nx),
    .halo_i     (halo_q),
    .coord_o    (cx),
    .in_range_o (okx),
    .class_o    (clsx)
  );

  pcb_axis #(.AxisBits(AxisBits)) u_axis_y (
    .clk_i      (clk_i),
    .adv_i      (axis_adv),
    .pos_i      (pos_y_i),
    .origin_i   (origin_y_q),
    .inv_len_i  (inv_y_q),
    .count_i    (ny),
    .halo_i     (halo_q),
    .coord_o    (cy),
    .in_range_o (oky),
    .class_o    (clsy)
  );

  pcb_axis #(.AxisBits(AxisBits)) u_axis_z (
    .clk_i      (clk_i),
    .adv_i      (axis_adv),
    .pos_i      (pos_z_i),
    .origin_i   (origin_z_q),
    .inv_len_i  (inv_z_q),
    .count_i    (nz),
    .halo_i     (halo_q),
    .coord_o    (cz),
    .in_range_o (okz),
    .class_o    (clsz)
  );

  // --------------------------------------------------------------------------
  // Stage 3: z*ny + y, merge classes
  // --------------------------------------------------------------------------
  pcb_pkg::cell_class_e cls_xy, cls_d, cls_q;
  logic [IdxW-1:0]      zy_d, zy_q;
  logic [AxisBits-1:0]  cx_q;
  logic                 ok_q;

  assign cls_xy = (clsy > clsx) ? clsy : clsx;
  assign cls_d  = (clsz > cls_xy) ? clsz : cls_xy;
  assign zy_d   = IdxW'(cz) * IdxW'(ny) + IdxW'(cy);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      zy_q  <= zy_d;
      cx_q  <= cx;
      ok_q  <= okx && oky && okz;
      cls_q <= cls_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: (z*ny + y)*nx + x into the output register
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] idx_d;

  assign idx_d = zy_q * IdxW'(nx) + IdxW'(cx_q);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      cell_index_o   <= ok_q ? idx_d : '0;
      cell_class_o   <= ok_q ? cls_q : pcb_pkg::CLASS_INNER;
      out_of_range_o <= !ok_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PCB_ASSERT_IMP(a_oor_clears_fields, out_valid_o && out_of_range_o,
                  cell_index_o == '0 && cell_class_o == pcb_pkg::CLASS_INNER,
                  "out-of-range word carries a nonzero index or class")

  `PCB_ASSERT_IMP(a_no_halo_all_inner, out_valid_o && halo_q == '0,
                  cell_class_o == pcb_pkg::CLASS_INNER,
                  "zero halo width gave a non-inner cell")

  `PCB_ASSERT_IMP(a_full_stalled_holds_input, (&valid_q) && out_stall_i, in_stall_o,
                  "full stalled pipeline still takes input")

endmodule
